>>> rtl/ubs_pkg.sv
package ubs_pkg;

  localparam int INTERVAL_BITS = 26;

  // Register reset values
  localparam logic [INTERVAL_BITS-1:0] RST_INITIAL  = INTERVAL_BITS'(60000);
  localparam logic [INTERVAL_BITS-1:0] RST_UNSENT   = INTERVAL_BITS'(15000);
  localparam logic [INTERVAL_BITS-1:0] RST_STANDARD = INTERVAL_BITS'(1800000);
  localparam logic [INTERVAL_BITS-1:0] RST_MAX      = INTERVAL_BITS'(18000000);

  // floor(x / 10) as (x * RECIP) >> RECIP_SHIFT, exact for every x below 2**INTERVAL_BITS
  localparam int RECIP_SHIFT = INTERVAL_BITS + 4;
  localparam longint unsigned RecipFull = ((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10;
  localparam logic [INTERVAL_BITS:0] RECIP = RecipFull[INTERVAL_BITS:0];
  localparam int TENTH_BITS = INTERVAL_BITS - 3;

  typedef enum logic [2:0] {
    MODE_TICK           = 3'd0,
    MODE_START          = 3'd1,
    MODE_STOP           = 3'd2,
    MODE_FINISHED       = 3'd3,
    MODE_CANCELLED      = 3'd4,
    MODE_CANCELLED_PERM = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    CFG_INITIAL  = 2'd0,
    CFG_UNSENT   = 2'd1,
    CFG_STANDARD = 2'd2,
    CFG_MAX      = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       server_healthy;
    logic       more_logs;
  } item_t;

  typedef struct packed {
    logic                     upload_request;
    logic                     timer_active;
    logic                     upload_busy;
    logic [INTERVAL_BITS-1:0] current_interval;
    logic                     event_error;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> rtl/ubs_engine.sv
module ubs_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  ubs_pkg::item_t                    load_item,
  input  logic                              cfg_write_en,
  input  logic [1:0]                        cfg_index,
  input  logic [ubs_pkg::INTERVAL_BITS-1:0] cfg_data,
  input  ubs_pkg::queue_status_t            queue_status,
  output logic                              held,
  output logic                              push,
  output ubs_pkg::result_t                  push_data
);
  import ubs_pkg::*;

  localparam int IB = INTERVAL_BITS;

  item_t          stage_item;
  logic           held_next;

  logic [IB-1:0]  unsent_interval;
  logic [IB-1:0]  standard_interval;
  logic [IB-1:0]  backoff_ceiling;

  logic           run_enabled;
  logic           timer_armed;
  logic           upload_outstanding;
  logic [IB-1:0]  interval_now;
  logic [IB-1:0]  ticks_left;

  logic           run_enabled_next;
  logic           timer_armed_next;
  logic           upload_outstanding_next;
  logic [IB-1:0]  interval_now_next;
  logic [IB-1:0]  ticks_left_next;
  logic           request;
  logic           error;

  logic [2*IB:0]  tenth_prod;
  logic [TENTH_BITS-1:0] tenth;
  logic [IB:0]    grown;
  logic [IB-1:0]  backed_off;

  assign push      = held & ~queue_status.full;
  assign held_next = load | (held & ~push);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_item <= load_item;
    end
  end

  // interval_now / 10, registered; a tick always comes between a completion that
  // changes the interval and the next completion, so the value is always current
  assign tenth_prod = {{IB{1'b0}}, interval_now} * {{IB{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    tenth <= tenth_prod[2*IB:RECIP_SHIFT];
  end

  // x * 11 / 10 = x + x / 10, then clamp at the max register
  assign grown      = {1'b0, interval_now} + (IB+1)'(tenth);
  assign backed_off = (grown > {1'b0, backoff_ceiling}) ? backoff_ceiling : grown[IB-1:0];

  always_comb begin
    run_enabled_next        = run_enabled;
    timer_armed_next        = timer_armed;
    upload_outstanding_next = upload_outstanding;
    interval_now_next       = interval_now;
    ticks_left_next         = ticks_left;
    request                 = 1'b0;
    error                   = 1'b0;
    case (stage_item.mode)
      MODE_TICK: begin
        if (timer_armed) begin
          if (ticks_left <= IB'(1)) begin
            ticks_left_next         = '0;
            timer_armed_next        = 1'b0;
            upload_outstanding_next = 1'b1;
            request                 = 1'b1;
          end else begin
            ticks_left_next = ticks_left - IB'(1);
          end
        end
      end
      MODE_START: begin
        run_enabled_next = 1'b1;
        if (!timer_armed && !upload_outstanding) begin
          timer_armed_next = 1'b1;
          ticks_left_next  = interval_now;
        end
      end
      MODE_STOP: begin
        run_enabled_next = 1'b0;
      end
      MODE_FINISHED, MODE_CANCELLED, MODE_CANCELLED_PERM: begin
        if (!upload_outstanding) begin
          error = 1'b1;
        end else begin
          if (stage_item.mode == MODE_FINISHED) begin
            if (!stage_item.server_healthy) begin
              interval_now_next = backed_off;
            end else if (stage_item.more_logs) begin
              interval_now_next = unsent_interval;
            end else begin
              interval_now_next = standard_interval;
            end
          end else if (stage_item.mode == MODE_CANCELLED_PERM) begin
            interval_now_next = backed_off;
          end
          upload_outstanding_next = 1'b0;
          if (run_enabled && !timer_armed) begin
            timer_armed_next = 1'b1;
            ticks_left_next  = interval_now_next;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    push_data.upload_request   = request;
    push_data.timer_active     = timer_armed_next;
    push_data.upload_busy      = upload_outstanding_next;
    push_data.current_interval = interval_now_next;
    push_data.event_error      = error;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unsent_interval    <= RST_UNSENT;
      standard_interval  <= RST_STANDARD;
      backoff_ceiling    <= RST_MAX;
      run_enabled        <= 1'b0;
      timer_armed        <= 1'b0;
      upload_outstanding <= 1'b0;
      interval_now       <= RST_INITIAL;
      ticks_left         <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        // the initial interval is only ever used by loading it here
        CFG_INITIAL:  interval_now      <= cfg_data;
        CFG_UNSENT:   unsent_interval   <= cfg_data;
        CFG_STANDARD: standard_interval <= cfg_data;
        CFG_MAX:      backoff_ceiling   <= cfg_data;
        default: begin
        end
      endcase
    end else if (push) begin
      run_enabled        <= run_enabled_next;
      timer_armed        <= timer_armed_next;
      upload_outstanding <= upload_outstanding_next;
      interval_now       <= interval_now_next;
      ticks_left         <= ticks_left_next;
    end
  end

endmodule

>>> rtl/ubs_out_queue.sv
module ubs_out_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ubs_pkg::result_t       push_data,
  input  logic                   pop,
  output ubs_pkg::result_t       head,
  output ubs_pkg::queue_status_t status
);
  import ubs_pkg::*;

  result_t    slot0;
  result_t    slot1;
  logic [1:0] count;
  logic [1:0] count_next;

  assign head         = slot0;
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // advance the second slot on a pop, fill the first free slot on a push
  always_ff @(posedge clk) begin
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      slot0 <= push_data;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (push && count == 2'd1 && !pop) begin
      slot1 <= push_data;
    end
  end

endmodule

>>> rtl/upload_backoff_scheduler_core.sv
// Upload scheduler with retry backoff.
// Input channel (item_valid / item_stall / item): one event per beat - tick,
// start, stop, upload finished, upload cancelled, cancelled for permission.
// Output channel (result_valid / result_stall / result): exactly one result
// beat per event, in order, carrying the request and error flags, the armed
// and busy flags and the current interval after the event.
// Configuration: cfg_write_en with cfg_index and cfg_data writes one of the
// four interval registers; write only while no event is in flight.
// Path: a taken event waits in the input register, is evaluated there against
// the scheduler state and moves into a two-entry output queue once it has room;
// the result is offered from the head of that queue.
// Throughput: one event per cycle while item_stall is low; the state update is a single short step.
// The backed-off interval uses x / 10 from a registered reciprocal product,
// then one add and a clamp against the max register.
// Stall: the output queue absorbs the result; item_stall rises only when the
// input register holds an event and the queue is full, and falls the cycle
// after the receiver takes a beat.
// Reset: flags and countdown clear, registers and the interval return to
// their defaults, both channels go empty.
module upload_backoff_scheduler_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  ubs_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output ubs_pkg::result_t                  result,
  input  logic                              cfg_write_en,
  input  logic [1:0]                        cfg_index,
  input  logic [ubs_pkg::INTERVAL_BITS-1:0] cfg_data
);
  import ubs_pkg::*;

  logic          item_take;
  logic          result_take;
  logic          held;
  logic          push;
  result_t       push_data;
  queue_status_t queue_status;

  // hold the input while its register is occupied and cannot drain
  assign item_stall   = held & queue_status.full;
  assign item_take    = item_valid & ~item_stall;
  assign result_valid = ~queue_status.empty;
  assign result_take  = result_valid & ~result_stall;

  // evaluate each event against the scheduler state
  ubs_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .load         (item_take),
    .load_item    (item),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .queue_status (queue_status),
    .held         (held),
    .push         (push),
    .push_data    (push_data)
  );

  // decouple the result beat from the receiver's stall
  ubs_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (result_take),
    .head      (result),
    .status    (queue_status)
  );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ubs_pkg::*;

  localparam int IB = INTERVAL_BITS;
  localparam logic [IB-1:0] IV_TOP = '1;
  // Mode codes outside the defined set: the block must leave them alone
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 120;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  logic    cfg_write_en;
  logic [1:0]    cfg_index;
  logic [IB-1:0] cfg_data;

  upload_backoff_scheduler_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scheduler shadow: registers, flags, countdown and interval as the block
  // should hold them after every beat accepted so far.
  // ---------------------------------------------------------------------------
  logic [IB-1:0] interval_reg [4];
  logic          sched_running;
  logic          sched_armed;
  logic          sched_busy;
  logic [IB-1:0] sched_interval;
  logic [IB-1:0] sched_ticks;

  result_t     pending_status [$];
  int unsigned mismatch_count;

  // Shared between the sender and the receiver process
  logic hold_request;
  logic gaps_off;

  // Arm only from a fully idle scheduler: not counting and nothing in flight
  function automatic void arm_countdown();
    if (!sched_armed && !sched_busy) begin
      sched_armed = 1'b1;
      sched_ticks = sched_interval;
    end
  endfunction

  // Grow by 11/10 with truncation, computed wide so the product never wraps,
  // then clamp to the max register (also when already above it)
  function automatic logic [IB-1:0] backed_off(input logic [IB-1:0] ivl);
    longint unsigned grown;
    grown = 64'(ivl) * 64'd11 / 64'd10;
    if (grown > 64'(interval_reg[CFG_MAX])) grown = 64'(interval_reg[CFG_MAX]);
    return IB'(grown);
  endfunction

  // Advance the shadow by one event and return the status beat it produces
  function automatic result_t schedule_event(input item_t e);
    result_t r;
    r = '0;
    case (e.mode)
      MODE_TICK: begin
        if (sched_armed) begin
          if (sched_ticks != 0) sched_ticks = sched_ticks - 1'b1;
          if (sched_ticks == 0) begin
            sched_armed      = 1'b0;
            sched_busy       = 1'b1;
            r.upload_request = 1'b1;
          end
        end
      end
      MODE_START: begin
        sched_running = 1'b1;
        arm_countdown();
      end
      MODE_STOP: begin
        // Stop leaves a pending countdown armed
        sched_running = 1'b0;
      end
      MODE_FINISHED, MODE_CANCELLED, MODE_CANCELLED_PERM: begin
        if (!sched_busy) begin
          r.event_error = 1'b1;
        end else begin
          if (e.mode == MODE_FINISHED) begin
            if (!e.server_healthy) sched_interval = backed_off(sched_interval);
            else if (e.more_logs) sched_interval = interval_reg[CFG_UNSENT];
            else sched_interval = interval_reg[CFG_STANDARD];
          end else if (e.mode == MODE_CANCELLED_PERM) begin
            sched_interval = backed_off(sched_interval);
          end
          sched_busy = 1'b0;
          if (sched_running) arm_countdown();
        end
      end
      default: begin
      end
    endcase
    r.timer_active     = sched_armed;
    r.upload_busy      = sched_busy;
    r.current_interval = sched_interval;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All drive at the rising edge with nonblocking writes and
  // return at an edge without having touched item_valid in that step.
  // ---------------------------------------------------------------------------

  // Offer one event, idling at random first; record the expected status once
  // the beat is taken. A typed-in expectation overrides the shadow's.
  task automatic offer_event(input item_t e, input bit use_known, input result_t known);
    result_t predicted;
    while (!gaps_off && $urandom_range(99) < 11) begin
      item_valid <= 1'b0;
      item       <= item_t'($urandom);
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= e;
    do @(posedge clk); while (item_stall);
    predicted = schedule_event(e);
    pending_status.push_back(use_known ? known : predicted);
  endtask

  // Drop valid and hold until every expected status beat has arrived
  task automatic settle();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [IB-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    interval_reg[idx] = value;
    if (idx == CFG_INITIAL) sched_interval = value;
    @(posedge clk);
  endtask

  // Random event shaped by the shadow: while an upload is out, half
  // completions; otherwise mostly ticks, with stray completions as noise
  function automatic item_t random_event();
    item_t       e;
    int unsigned pick;
    e.server_healthy = 1'($urandom_range(1));
    e.more_logs      = 1'($urandom_range(1));
    pick             = $urandom_range(99);
    if (sched_busy) begin
      if (pick < 30) e.mode = MODE_FINISHED;
      else if (pick < 40) e.mode = MODE_CANCELLED;
      else if (pick < 50) e.mode = MODE_CANCELLED_PERM;
      else if (pick < 85) e.mode = MODE_TICK;
      else if (pick < 93) e.mode = MODE_START;
      else if (pick < 98) e.mode = MODE_STOP;
      else e.mode = 3'($urandom_range(7, 6));
    end else begin
      if (pick < 70) e.mode = MODE_TICK;
      else if (pick < 82) e.mode = MODE_START;
      else if (pick < 90) e.mode = MODE_STOP;
      else if (pick < 97) e.mode = 3'($urandom_range(5, 3));
      else e.mode = 3'($urandom_range(7, 6));
    end
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan: register writes and events in order. Rows whose status is
  // obvious carry it typed in; the rest lean on the shadow.
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {ROW_EVENT, ROW_EVENT_KNOWN, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    item_t         ev;
    result_t       known;
    cfg_index_t    idx;
    logic [IB-1:0] value;
  } plan_row_t;

  plan_row_t directed_plan [$];

  function automatic plan_row_t ev(input logic [2:0] m, input logic h, input logic l);
    plan_row_t row;
    row.kind              = ROW_EVENT;
    row.ev                = '0;
    row.known             = '0;
    row.idx               = CFG_INITIAL;
    row.value             = '0;
    row.ev.mode           = m;
    row.ev.server_healthy = h;
    row.ev.more_logs      = l;
    return row;
  endfunction

  function automatic plan_row_t ev_known(input logic [2:0] m, input logic h, input logic l,
                                         input logic rq, input logic ta, input logic ub,
                                         input logic [IB-1:0] iv, input logic er);
    plan_row_t row;
    row                        = ev(m, h, l);
    row.kind                   = ROW_EVENT_KNOWN;
    row.known.upload_request   = rq;
    row.known.timer_active     = ta;
    row.known.upload_busy      = ub;
    row.known.current_interval = iv;
    row.known.event_error      = er;
    return row;
  endfunction

  function automatic plan_row_t reg_write(input cfg_index_t i, input logic [IB-1:0] v);
    plan_row_t row;
    row.kind  = ROW_WRITE;
    row.ev    = '0;
    row.known = '0;
    row.idx   = i;
    row.value = v;
    return row;
  endfunction

  // Random sweeps: one register setting per sweep
  typedef struct {
    logic [IB-1:0] init_ivl;
    logic [IB-1:0] unsent_ivl;
    logic [IB-1:0] std_ivl;
    logic [IB-1:0] max_ivl;
    int unsigned   beats;
    bit            squeeze;
    bit            steady;
  } sweep_t;

  sweep_t sweeps [$];

  function automatic sweep_t sweep_step(input logic [IB-1:0] i, u, s, m,
                                        input int unsigned n, input bit squeeze, steady);
    sweep_t sw;
    sw.init_ivl   = i;
    sw.unsent_ivl = u;
    sw.std_ivl    = s;
    sw.max_ivl    = m;
    sw.beats      = n;
    sw.squeeze    = squeeze;
    sw.steady     = steady;
    return sw;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, none while gaps are off, and one long hold-off
  // per request so the output queue fills and the input backs up.
  // ---------------------------------------------------------------------------
  int unsigned hold_left;
  bit          hold_done;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      result_stall <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      if (!hold_request) hold_done <= 1'b0;
      result_stall <= !gaps_off && ($urandom_range(99) < 11);
    end
  end

  // ---------------------------------------------------------------------------
  // Status checker: each beat taken is compared with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [IB-1:0] want,
                               input logic [IB-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_status.size() == 0) begin
        $error("status beat with nothing outstanding: got %h", result);
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        compare_field("upload_request", IB'(want.upload_request), IB'(result.upload_request));
        compare_field("timer_active", IB'(want.timer_active), IB'(result.timer_active));
        compare_field("upload_busy", IB'(want.upload_busy), IB'(result.upload_busy));
        compare_field("current_interval", want.current_interval, result.current_interval);
        compare_field("event_error", IB'(want.event_error), IB'(result.event_error));
      end
    end
  end

  // Watchdog: give up when nothing moves on any port for too long
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    item_valid     = 1'b0;
    item           = '0;
    result_stall   = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    hold_request   = 1'b0;
    gaps_off       = 1'b0;
    hold_left      = 0;
    hold_done      = 1'b0;
    quiet_cycles   = 0;
    mismatch_count = 0;

    interval_reg[CFG_INITIAL]  = RST_INITIAL;
    interval_reg[CFG_UNSENT]   = RST_UNSENT;
    interval_reg[CFG_STANDARD] = RST_STANDARD;
    interval_reg[CFG_MAX]      = RST_MAX;
    sched_running  = 1'b0;
    sched_armed    = 1'b0;
    sched_busy     = 1'b0;
    sched_interval = RST_INITIAL;
    sched_ticks    = '0;

    // Out of reset: completions with nothing outstanding are flagged and
    // ignored, idle ticks, spare modes and stop change nothing
    directed_plan.push_back(ev_known(MODE_FINISHED, 0, 0, 0, 0, 0, RST_INITIAL, 1));
    directed_plan.push_back(ev_known(MODE_CANCELLED, 1, 0, 0, 0, 0, RST_INITIAL, 1));
    directed_plan.push_back(ev_known(MODE_CANCELLED_PERM, 1, 1, 0, 0, 0, RST_INITIAL, 1));
    directed_plan.push_back(ev_known(MODE_TICK, 1, 1, 0, 0, 0, RST_INITIAL, 0));
    directed_plan.push_back(ev_known(MODE_SPARE_A, 0, 1, 0, 0, 0, RST_INITIAL, 0));
    directed_plan.push_back(ev_known(MODE_SPARE_B, 1, 1, 0, 0, 0, RST_INITIAL, 0));
    directed_plan.push_back(ev_known(MODE_STOP, 0, 0, 0, 0, 0, RST_INITIAL, 0));
    directed_plan.push_back(reg_write(CFG_UNSENT, IV_TOP));
    directed_plan.push_back(reg_write(CFG_STANDARD, IB'(5)));
    directed_plan.push_back(reg_write(CFG_MAX, IB'(40)));
    directed_plan.push_back(reg_write(CFG_INITIAL, '0));
    // Zero interval: arm, stop leaves it armed, first tick fires
    directed_plan.push_back(ev_known(MODE_START, 0, 0, 0, 1, 0, '0, 0));
    directed_plan.push_back(ev(MODE_STOP, 0, 0));
    directed_plan.push_back(ev_known(MODE_TICK, 0, 0, 1, 0, 1, '0, 0));
    directed_plan.push_back(ev(MODE_TICK, 1, 0));
    directed_plan.push_back(ev(MODE_STOP, 1, 1));
    // Backoff past max clamps; not running, so no rearm
    directed_plan.push_back(reg_write(CFG_INITIAL, IB'(38)));
    directed_plan.push_back(ev(MODE_FINISHED, 0, 1));
    directed_plan.push_back(reg_write(CFG_INITIAL, '0));
    directed_plan.push_back(ev(MODE_START, 0, 0));
    directed_plan.push_back(ev(MODE_TICK, 0, 1));
    // Start while an upload is out: runs, but no rearm
    directed_plan.push_back(ev(MODE_START, 1, 1));
    directed_plan.push_back(ev(MODE_CANCELLED_PERM, 1, 0));
    directed_plan.push_back(ev(MODE_TICK, 0, 0));
    directed_plan.push_back(ev(MODE_STOP, 0, 0));
    directed_plan.push_back(ev(MODE_FINISHED, 1, 1));
    directed_plan.push_back(ev_known(MODE_CANCELLED, 0, 1, 0, 0, 0, IV_TOP, 1));
    // Top interval backed off: the wide product must clamp, not wrap
    directed_plan.push_back(reg_write(CFG_INITIAL, '0));
    directed_plan.push_back(ev(MODE_START, 1, 0));
    directed_plan.push_back(ev(MODE_TICK, 1, 1));
    directed_plan.push_back(reg_write(CFG_INITIAL, IV_TOP));
    directed_plan.push_back(ev(MODE_STOP, 0, 1));
    directed_plan.push_back(ev(MODE_CANCELLED_PERM, 0, 0));
    directed_plan.push_back(reg_write(CFG_MAX, IV_TOP));
    directed_plan.push_back(reg_write(CFG_INITIAL, '0));
    directed_plan.push_back(ev(MODE_START, 0, 0));
    directed_plan.push_back(ev(MODE_TICK, 0, 0));
    directed_plan.push_back(ev(MODE_CANCELLED, 1, 1));
    directed_plan.push_back(ev(MODE_TICK, 0, 0));
    directed_plan.push_back(ev(MODE_FINISHED, 1, 0));

    // Small intervals keep uploads frequent; one sweep with all zeros, one
    // with the standard interval above max, one with max at its top
    sweeps.push_back(sweep_step(IB'(3), IB'(1), IB'(8), IB'(20), 220, 0, 0));
    sweeps.push_back(sweep_step('0, '0, '0, '0, 200, 0, 0));
    sweeps.push_back(sweep_step(IB'(12), IB'(25), IB'(40), IB'(30), 220, 1, 0));
    sweeps.push_back(sweep_step(IB'($urandom_range(31)), IB'($urandom_range(31)),
                                IB'($urandom_range(31)), IB'($urandom_range(31)),
                                240, 0, 1));
    sweeps.push_back(sweep_step(IB'(7), IB'(15), IB'(2), IV_TOP, 220, 0, 0));
    sweeps.push_back(sweep_step(IB'($urandom_range(63)), IB'($urandom_range(63)),
                                IB'($urandom_range(63)), IB'($urandom_range(63)),
                                250, 0, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[k]) begin
      if (directed_plan[k].kind == ROW_WRITE) begin
        // Registers change only with nothing in flight
        settle();
        write_reg(directed_plan[k].idx, directed_plan[k].value);
      end else begin
        offer_event(directed_plan[k].ev, directed_plan[k].kind == ROW_EVENT_KNOWN,
                    directed_plan[k].known);
      end
    end

    foreach (sweeps[p]) begin
      settle();
      write_reg(CFG_UNSENT, sweeps[p].unsent_ivl);
      write_reg(CFG_STANDARD, sweeps[p].std_ivl);
      write_reg(CFG_MAX, sweeps[p].max_ivl);
      write_reg(CFG_INITIAL, sweeps[p].init_ivl);
      hold_request <= sweeps[p].squeeze;
      gaps_off     <= sweeps[p].steady;
      repeat (sweeps[p].beats) offer_event(random_event(), 1'b0, '0);
      hold_request <= 1'b0;
      gaps_off     <= 1'b0;
    end

    settle();
    // Wait on in case a stray beat follows
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
